### rtl/mwf_pkg.sv
// Shared types, constants and helpers for the morphology window filter.
// Used by every module under rtl; depends on nothing else.
package mwf_pkg;

  localparam int PIX_W      = 8;
  localparam int ROW_W      = 12;
  localparam int CCOL_W     = 11;
  localparam int HGT_W      = 13;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 13;
  localparam int S_TDATA_W  = 8;
  localparam int M_TDATA_W  = 32;

  localparam logic [PIX_W-1:0] FG_VALUE = 8'd255;
  localparam logic [PIX_W-1:0] BG_VALUE = 8'd0;
  localparam logic [HGT_W-1:0] MAX_HGT  = 13'd4096;
  localparam int               HGT_RST  = 480;
  localparam int               WID_RST  = 640;
  localparam int               RAD_RST  = 1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FRAME_WIDTH   = 3'd0,
    CFG_FRAME_HEIGHT  = 3'd1,
    CFG_WINDOW_RADIUS = 3'd2,
    CFG_DILATE_MODE   = 3'd3,
    CFG_BINARY_MODE   = 3'd4
  } cfg_reg_e;

  // Per-pixel tag that rides along the pipeline
  typedef struct packed {
    logic              emit;
    logic              last;
    logic [ROW_W-1:0]  centre_row;
    logic [CCOL_W-1:0] centre_col;
  } tag_t;

  // Min for erosion, max for dilation
  function automatic logic [PIX_W-1:0] pick(input logic [PIX_W-1:0] a,
                                            input logic [PIX_W-1:0] b,
                                            input logic             dilate);
    if (dilate) begin
      pick = (a > b) ? a : b;
    end else begin
      pick = (a < b) ? a : b;
    end
  endfunction

endpackage

### rtl/mwf_pos.sv
// Raster position tracking: row, column and line-slot counters, border test.
// Depends on mwf_pkg.
module mwf_pos #(
  parameter int MAX_WIDTH  = 2048,
  parameter int MAX_RADIUS = 3,
  localparam int CW    = $clog2(MAX_WIDTH),
  localparam int WW    = CW + 1,
  localparam int SLOTS = 2 * MAX_RADIUS,
  localparam int SW    = $clog2(SLOTS),
  localparam int RW    = $clog2(MAX_RADIUS + 1)
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    step_i,
  input  logic                    frame_start_i,
  input  logic [WW-1:0]           width_i,
  input  logic [mwf_pkg::HGT_W-1:0] height_i,
  input  logic [RW-1:0]           radius_i,
  output logic [CW-1:0]           col_o,
  output logic [SW-1:0]           slot_o,
  output mwf_pkg::tag_t           tag_o
);
  import mwf_pkg::*;

  logic [CW-1:0]    col_q, col_d, c0, c;
  logic [ROW_W-1:0] row_q, row_d;
  logic [SW-1:0]    slot_q, slot_d, s0, s1, s;
  logic [HGT_W-1:0] r0, r1, r, r2, two_r_h;
  logic [WW-1:0]    c_nx, two_r_w;
  logic             wrap_c;

  function automatic logic [SW-1:0] slot_inc(input logic [SW-1:0] v);
    slot_inc = (v == SW'(SLOTS - 1)) ? '0 : v + 1'b1;
  endfunction

  // Resolve the position of this pixel, then the position of the next one
  always_comb begin
    c0 = frame_start_i ? '0 : col_q;
    r0 = frame_start_i ? '0 : HGT_W'(row_q);
    s0 = frame_start_i ? '0 : slot_q;
    wrap_c = ({1'b0, c0} >= width_i);
    c  = wrap_c ? '0 : c0;
    r1 = wrap_c ? r0 + 1'b1 : r0;
    s1 = wrap_c ? slot_inc(s0) : s0;
    if (r1 >= height_i) begin
      r = '0;
      s = '0;
    end else begin
      r = r1;
      s = s1;
    end

    c_nx  = {1'b0, c} + 1'b1;
    r2    = r + 1'b1;
    col_d = c;
    row_d = ROW_W'(r);
    slot_d = s;
    if (c_nx >= width_i) begin
      col_d = '0;
      if (r2 >= height_i) begin
        row_d  = '0;
        slot_d = '0;
      end else begin
        row_d  = ROW_W'(r2);
        slot_d = slot_inc(s);
      end
    end else begin
      col_d = c_nx[CW-1:0];
    end

    two_r_h = HGT_W'({radius_i, 1'b0});
    two_r_w = WW'({radius_i, 1'b0});
    tag_o.emit       = (r >= two_r_h) && ({1'b0, c} >= two_r_w);
    tag_o.last       = (r == height_i - 1'b1) && ({1'b0, c} == width_i - 1'b1);
    tag_o.centre_row = ROW_W'(r - HGT_W'(radius_i));
    tag_o.centre_col = CCOL_W'({1'b0, c} - WW'(radius_i));
    col_o  = c;
    slot_o = s;
  end

  // Advance counters on each pixel beat
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q  <= '0;
      row_q  <= '0;
      slot_q <= '0;
    end else if (step_i) begin
      col_q  <= col_d;
      row_q  <= row_d;
      slot_q <= slot_d;
    end
  end

endmodule

### rtl/mwf_line_buf.sv
// Line buffer: one single-port-write / single-read memory per stored row slot.
// Depends on mwf_pkg.
module mwf_line_buf #(
  parameter int MAX_WIDTH  = 2048,
  parameter int MAX_RADIUS = 3,
  localparam int CW    = $clog2(MAX_WIDTH),
  localparam int SLOTS = 2 * MAX_RADIUS,
  localparam int SW    = $clog2(SLOTS)
) (
  input  logic                                 clk_i,
  input  logic                                 en_i,
  input  logic                                 wr_i,
  input  logic [SW-1:0]                        slot_i,
  input  logic [CW-1:0]                        col_i,
  input  logic [mwf_pkg::PIX_W-1:0]            pix_i,
  output logic [SLOTS-1:0][mwf_pkg::PIX_W-1:0] rd_o
);
  import mwf_pkg::*;

  // Write the current pixel into its slot, read every slot at the same column
  for (genvar j = 0; j < SLOTS; j++) begin : g_slot
    logic [PIX_W-1:0] mem [MAX_WIDTH];
    logic [PIX_W-1:0] rd_q;

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (wr_i && (slot_i == SW'(j))) begin
          mem[col_i] <= pix_i;
        end
        rd_q <= mem[col_i];
      end
    end

    assign rd_o[j] = rd_q;
  end

endmodule

### rtl/mwf_window.sv
// Window datapath: reduce each new column, shift column summaries, reduce window.
// Depends on mwf_pkg.
module mwf_window #(
  parameter int MAX_RADIUS = 3,
  localparam int SLOTS = 2 * MAX_RADIUS,
  localparam int SIDE  = 2 * MAX_RADIUS + 1,
  localparam int SW    = $clog2(SLOTS),
  localparam int RW    = $clog2(MAX_RADIUS + 1)
) (
  input  logic                                 clk_i,
  input  logic                                 shift_i,
  input  logic [mwf_pkg::PIX_W-1:0]            pix_i,
  input  logic [SLOTS-1:0][mwf_pkg::PIX_W-1:0] rd_i,
  input  logic [SW-1:0]                        slot_i,
  input  logic [RW-1:0]                        radius_i,
  input  logic                                 dilate_i,
  input  logic                                 binary_i,
  output logic [mwf_pkg::PIX_W-1:0]            result_o
);
  import mwf_pkg::*;

  logic [PIX_W-1:0] colsum_q [SIDE];
  logic [PIX_W-1:0] col_acc, win_acc;

  // Fold the new column: current pixel plus the stored rows above it
  always_comb begin
    int k, j, span;
    span    = 2 * int'(radius_i);
    col_acc = pix_i;
    for (k = 1; k < SIDE; k++) begin
      j = int'(slot_i) - k;
      if (j < 0) begin
        j = j + SLOTS;
      end
      if (k <= span) begin
        col_acc = pick(col_acc, rd_i[SW'(j)], dilate_i);
      end
    end
  end

  // Shift column summaries one column older
  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      colsum_q[0] <= col_acc;
      for (int i = 1; i < SIDE; i++) begin
        colsum_q[i] <= colsum_q[i-1];
      end
    end
  end

  // Fold the active columns; binary mode tests the fold against foreground
  always_comb begin
    int c, span;
    span    = 2 * int'(radius_i);
    win_acc = colsum_q[0];
    for (c = 1; c < SIDE; c++) begin
      if (c <= span) begin
        win_acc = pick(win_acc, colsum_q[c], dilate_i);
      end
    end
    if (binary_i) begin
      result_o = (win_acc == FG_VALUE) ? FG_VALUE : BG_VALUE;
    end else begin
      result_o = win_acc;
    end
  end

endmodule

### rtl/morphology_window_filter_core.sv
// Top level of the square-window erosion / dilation filter.
// Depends on mwf_pkg, mwf_pos, mwf_line_buf and mwf_window.
//
//  channel | dir | handshake                    | payload
//  --------+-----+------------------------------+------------------------------------
//  s_axis  | in  | s_axis_tvalid/s_axis_tready  | tdata pixel_value, tuser frame_start
//  m_axis  | out | m_axis_tvalid/m_axis_tready  | tdata result/row/col, tlast frame_last
//  cfg     | in  | cfg_valid_i/cfg_ready_o      | cfg_index_i register, cfg_data_i value
//
// One pixel beat per cycle while s_axis_tready is high; a result passes the input
// register, line-buffer read, column fold and output register on its way out.
// s_axis_tready drops only while the output skid register holds a beat.
// Reset clears counters and valid bits and loads config defaults; no clearing pass is run:
// line-buffer rows not yet written in the current frame feed only border pixels.
// Border pixels are consumed and produce no beat.
module morphology_window_filter_core #(
  parameter int MAX_WIDTH  = 2048,
  parameter int MAX_RADIUS = 3
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // [7:0] pixel_value
  input  logic [mwf_pkg::S_TDATA_W-1:0]       s_axis_tdata,
  // [0] frame_start
  input  logic                                s_axis_tuser,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // [7:0] result_value, [19:8] centre_row, [30:20] centre_col, [31] zero
  output logic [mwf_pkg::M_TDATA_W-1:0]       m_axis_tdata,
  output logic                                m_axis_tlast,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [mwf_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [mwf_pkg::CFG_DATA_W-1:0]      cfg_data_i
);
  import mwf_pkg::*;

  localparam int CW    = $clog2(MAX_WIDTH);
  localparam int WW    = CW + 1;
  localparam int SLOTS = 2 * MAX_RADIUS;
  localparam int SW    = $clog2(SLOTS);
  localparam int RW    = $clog2(MAX_RADIUS + 1);
  localparam int W_RST = (WID_RST > MAX_WIDTH) ? MAX_WIDTH : WID_RST;
  localparam int R_RST = (RAD_RST > MAX_RADIUS) ? MAX_RADIUS : RAD_RST;

  localparam int OUT_W = PIX_W + ROW_W + CCOL_W + 1;

  // Config registers, stored already clamped
  logic [WW-1:0]    width_q;
  logic [HGT_W-1:0] height_q;
  logic [RW-1:0]    radius_q;
  logic             dilate_q, binary_q;

  // Pipeline
  logic                   en;
  logic                   v1_q, v2_q, v3_q;
  logic [PIX_W-1:0]       pix1_q, pix2_q;
  logic                   fs1_q;
  tag_t                   tag_d, tag2_q, tag3_q;
  logic [SW-1:0]          slot_d, slot2_q;
  logic [CW-1:0]          col_d;
  logic [SLOTS-1:0][PIX_W-1:0] rd;
  logic [PIX_W-1:0]       win_res;
  logic                   res_v;
  logic [OUT_W-1:0]       res_beat;

  // Output and skid registers
  logic                   out_v_q, skid_v_q;
  logic [OUT_W-1:0]       out_q, skid_q;

  assign cfg_ready_o   = 1'b1;
  assign en            = !skid_v_q;
  assign s_axis_tready = en;

  // Config writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= WW'(W_RST);
      height_q <= HGT_W'(HGT_RST);
      radius_q <= RW'(R_RST);
      dilate_q <= 1'b0;
      binary_q <= 1'b0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_reg_e'(cfg_index_i))
        CFG_FRAME_WIDTH: begin
          if (32'(cfg_data_i[11:0]) > 32'(MAX_WIDTH)) begin
            width_q <= WW'(MAX_WIDTH);
          end else if (cfg_data_i[11:0] == 12'd0) begin
            width_q <= WW'(1);
          end else begin
            width_q <= WW'(cfg_data_i[11:0]);
          end
        end
        CFG_FRAME_HEIGHT: begin
          if (cfg_data_i > MAX_HGT) begin
            height_q <= MAX_HGT;
          end else if (cfg_data_i == '0) begin
            height_q <= HGT_W'(1);
          end else begin
            height_q <= cfg_data_i;
          end
        end
        CFG_WINDOW_RADIUS: begin
          if (32'(cfg_data_i[1:0]) > 32'(MAX_RADIUS)) begin
            radius_q <= RW'(MAX_RADIUS);
          end else begin
            radius_q <= RW'(cfg_data_i[1:0]);
          end
        end
        CFG_DILATE_MODE: dilate_q <= cfg_data_i[0];
        CFG_BINARY_MODE: binary_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Valid bits of the pipeline stages
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (en) begin
      v1_q <= s_axis_tvalid;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  // Stage payloads
  always_ff @(posedge clk_i) begin
    if (en) begin
      if (s_axis_tvalid) begin
        pix1_q <= s_axis_tdata[PIX_W-1:0];
        fs1_q  <= s_axis_tuser;
      end
      pix2_q  <= pix1_q;
      tag2_q  <= tag_d;
      slot2_q <= slot_d;
      tag3_q  <= tag2_q;
    end
  end

  mwf_pos #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_RADIUS (MAX_RADIUS)
  ) u_pos (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .step_i        (en && v1_q),
    .frame_start_i (fs1_q),
    .width_i       (width_q),
    .height_i      (height_q),
    .radius_i      (radius_q),
    .col_o         (col_d),
    .slot_o        (slot_d),
    .tag_o         (tag_d)
  );

  mwf_line_buf #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_RADIUS (MAX_RADIUS)
  ) u_line_buf (
    .clk_i  (clk_i),
    .en_i   (en),
    .wr_i   (v1_q),
    .slot_i (slot_d),
    .col_i  (col_d),
    .pix_i  (pix1_q),
    .rd_o   (rd)
  );

  mwf_window #(
    .MAX_RADIUS (MAX_RADIUS)
  ) u_window (
    .clk_i    (clk_i),
    .shift_i  (en && v2_q),
    .pix_i    (pix2_q),
    .rd_i     (rd),
    .slot_i   (slot2_q),
    .radius_i (radius_q),
    .dilate_i (dilate_q),
    .binary_i (binary_q),
    .result_o (win_res)
  );

  assign res_v    = v3_q && tag3_q.emit;
  assign res_beat = {tag3_q.last, tag3_q.centre_col, tag3_q.centre_row, win_res};

  // Output register with skid: hold a beat in the skid while the sink stalls
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else if (skid_v_q) begin
      if (m_axis_tready) begin
        skid_v_q <= 1'b0;
      end
    end else if (!out_v_q || m_axis_tready) begin
      out_v_q <= res_v;
    end else if (res_v) begin
      skid_v_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_v_q) begin
      if (m_axis_tready) begin
        out_q <= skid_q;
      end
    end else if (!out_v_q || m_axis_tready) begin
      out_q <= res_beat;
    end else if (res_v) begin
      skid_q <= res_beat;
    end
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = M_TDATA_W'(out_q[OUT_W-2:0]);
  assign m_axis_tlast  = out_q[OUT_W-1];

  // A full skid always sits behind a valid output beat
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_v_q |-> out_v_q)
    else $error("skid holds a beat while the output register is empty");

  // A result leaving the window stage is never dropped
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (en && res_v) |=> out_v_q)
    else $error("result beat lost at the output register");

  // The skid fills only from a stalled output
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(skid_v_q) |-> $past(out_v_q && !m_axis_tready && res_v))
    else $error("skid loaded without a stalled output");

endmodule
